// ===== src/sfx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfx_pkg;

	// longest start-of-frame pattern in bytes
	localparam int MAX_SOF_LEN = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_SOF_PATTERN = 2'd0;
	localparam logic [1:0] CFG_SOF_LENGTH  = 2'd1;
	localparam logic [1:0] CFG_ID_VALUE    = 2'd2;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_HEADER = 1'b1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} ctrl_state_t;

	// deframer phase
	typedef enum logic [1:0] {
		PH_WAIT,
		PH_ID,
		PH_CNT
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // capture the incoming byte
		logic eval;  // update frame state and plan the results
		logic emit;  // move the next result into the output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic any_result; // evaluated item causes at least one result
		logic out_free;   // output register can take a result this cycle
		logic cur_last;   // result now offered for emit is the final one
	} dp_status_t;

	// pattern byte at a match index
	function automatic logic [7:0] pat_byte(input logic [63:0] pattern,
						input logic [2:0] idx);
		pat_byte = pattern[{idx, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

// ===== src/sfx_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfx_ctrl
	import sfx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval   = 1'b1;
				state_next = status.any_result ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.cur_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sfx_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfx_dp
	import sfx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic [7:0]  in_byte,
	input  wire ctrl_cmd_t   cmd,
	output dp_status_t       status,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic             out_kind,
	output logic [7:0]       out_byte,
	output logic [31:0]      out_counter,
	output logic [31:0]      out_position,
	output logic             out_last
);

	// configuration
	logic [63:0] sof_pattern_q;
	logic [3:0]  sof_length_q;
	logic [7:0]  id_value_q;

	// frame state
	phase_t      phase_q;
	logic        collecting_q;
	logic [3:0]  match_count_q;
	logic [1:0]  counter_index_q;
	logic [23:0] counter_bytes_q;
	logic [31:0] position_q;

	// captured item and result plan
	logic [7:0]  byte_q;
	logic [2:0]  rep_q;
	logic        tail_q;
	logic        hdr_q;
	logic [31:0] hdr_cnt_q;
	logic [2:0]  emit_idx_q;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_byte_q;
	logic [31:0] out_cnt_q;
	logic [31:0] out_pos_q;
	logic        out_last_q;

	// evaluation of the captured byte
	logic [7:0] first_b;
	logic [7:0] cur_b;
	logic [3:0] eff_len;
	logic       brk;
	logic [3:0] mc_step;
	logic [2:0] rep_next;
	logic       tail_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_pattern_q <= '0;
			sof_length_q  <= 4'd1;
			id_value_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOF_PATTERN: sof_pattern_q <= cfg_data;
				CFG_SOF_LENGTH:  sof_length_q  <= cfg_data[3:0];
				CFG_ID_VALUE:    id_value_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// pattern compare and match count step
	always_comb begin
		first_b = pat_byte(sof_pattern_q, 3'd0);
		cur_b   = pat_byte(sof_pattern_q, match_count_q[2:0]);
		if (sof_length_q == 4'd0) begin
			eff_len = 4'd1;
		end else if (sof_length_q > 4'(MAX_SOF_LEN)) begin
			eff_len = 4'(MAX_SOF_LEN);
		end else begin
			eff_len = sof_length_q;
		end
		brk       = collecting_q && (byte_q != cur_b);
		rep_next  = brk ? match_count_q[2:0] : 3'd0;
		tail_next = brk && (byte_q != first_b);
		if (byte_q == first_b) begin
			mc_step = 4'd1;
		end else if (byte_q == cur_b) begin
			mc_step = match_count_q + 4'd1;
		end else begin
			mc_step = 4'd0;
		end
	end

	// status to the controller
	always_comb begin
		status.out_free = !out_valid_q || out_ready;
		if (phase_q == PH_CNT) begin
			status.any_result = (counter_index_q == 2'd3);
		end else if (phase_q == PH_ID) begin
			status.any_result = 1'b0;
		end else begin
			status.any_result = (rep_next != 3'd0) || tail_next;
		end
		if (hdr_q) begin
			status.cur_last = 1'b1;
		end else if (emit_idx_q < rep_q) begin
			status.cur_last = (emit_idx_q == rep_q - 3'd1) && !tail_q;
		end else begin
			status.cur_last = 1'b1;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_WAIT;
			collecting_q    <= 1'b0;
			match_count_q   <= '0;
			counter_index_q <= '0;
			counter_bytes_q <= '0;
			position_q      <= '0;
			rep_q           <= '0;
			tail_q          <= 1'b0;
			hdr_q           <= 1'b0;
			emit_idx_q      <= '0;
		end else begin
			if (cmd.eval) begin
				rep_q      <= '0;
				tail_q     <= 1'b0;
				hdr_q      <= 1'b0;
				emit_idx_q <= '0;
				unique case (phase_q)
					PH_ID: begin
						phase_q <= (byte_q == id_value_q) ? PH_CNT : PH_WAIT;
					end
					PH_CNT: begin
						if (counter_index_q == 2'd3) begin
							hdr_q           <= 1'b1;
							counter_index_q <= '0;
							counter_bytes_q <= '0;
							phase_q         <= PH_WAIT;
							collecting_q    <= 1'b1;
						end else begin
							counter_bytes_q[{counter_index_q, 3'b000} +: 8] <= byte_q;
							counter_index_q <= counter_index_q + 2'd1;
						end
					end
					default: begin
						rep_q  <= rep_next;
						tail_q <= tail_next;
						if (mc_step >= eff_len) begin
							match_count_q <= '0;
							phase_q       <= PH_ID;
							collecting_q  <= 1'b0;
						end else begin
							match_count_q <= mc_step;
						end
					end
				endcase
			end
			// data results advance the output position
			if (cmd.emit && !hdr_q) begin
				position_q <= position_q + 32'd1;
				emit_idx_q <= emit_idx_q + 3'd1;
			end
		end
	end

	// captured byte and header counter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
		end
		if (cmd.eval) begin
			hdr_cnt_q <= {byte_q, counter_bytes_q};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q <= status.cur_last;
			if (hdr_q) begin
				out_kind_q <= KIND_HEADER;
				out_byte_q <= '0;
				out_cnt_q  <= hdr_cnt_q;
				out_pos_q  <= position_q;
			end else begin
				out_kind_q <= KIND_DATA;
				out_byte_q <= (emit_idx_q < rep_q) ?
					pat_byte(sof_pattern_q, emit_idx_q) : byte_q;
				out_cnt_q  <= '0;
				out_pos_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_byte     = out_byte_q;
	assign out_counter  = out_cnt_q;
	assign out_position = out_pos_q;
	assign out_last     = out_last_q;

endmodule

`default_nettype wire

// ===== src/sync_word_frame_extractor_unit.sv =====
// Start-of-frame deframer over a byte stream.
// s_axis carries one raw byte per item. m_axis carries results: tuser 0 is a
// payload byte in tdata[7:0], tuser 1 is a frame header with the frame counter
// in tdata[39:8] and the output byte position in tdata[71:40]. tlast marks the
// final result caused by one input byte; a byte may cause none or up to eight.
// cfg_we / cfg_index / cfg_data write sof_pattern (0), sof_length (1) and
// id_value (2) while the block is idle.
// Sequencing: a byte is taken in one cycle and evaluated in the next; its
// results then enter the single output register one after another, each
// when that register is free.
// Reset clears the frame state, the output valid flag and the configuration
// (pattern 0, length 1, identifier 0).
// When the receiver stalls, the pending result holds in the output register
// and the emit sequencer waits; the next input byte is taken only after the
// last result of the current one has entered the output register.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_extractor_unit
	import sfx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // out_byte, frame_counter, frame_position
	output logic             m_axis_tuser,   // kind
	output logic             m_axis_tlast    // last
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic [7:0]  res_byte;
	logic [31:0] res_counter;
	logic [31:0] res_position;

	// sequencing
	sfx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// frame state, result planning and output register
	sfx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (s_axis_tdata),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_kind     (m_axis_tuser),
		.out_byte     (res_byte),
		.out_counter  (res_counter),
		.out_position (res_position),
		.out_last     (m_axis_tlast)
	);

	// result packing, first field lowest
	assign m_axis_tdata = {res_position, res_counter, res_byte};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sfx_pkg::*;

	// index with no register behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [31:0] count;
		logic [31:0] pos;
		logic        last;
	} frame_res_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [63:0] val;
		logic [7:0]  b;
		bit          typed;
		bit          typed_any;
		frame_res_t  typed_res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // in_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // out_byte, frame_counter, frame_position
	logic        m_axis_tuser;   // kind
	logic        m_axis_tlast;   // last

	// deframer copy: configuration
	logic [63:0] cfg_pattern = '0;
	logic [3:0]  cfg_len = 4'd1;
	logic [7:0]  cfg_id = '0;

	// deframer copy: frame state
	phase_t      ph = PH_WAIT;
	logic        collecting = 1'b0;
	logic [3:0]  match_cnt = '0;
	logic [1:0]  cnt_idx = '0;
	logic [23:0] cnt_bytes = '0;
	logic [31:0] out_pos = '0;

	frame_res_t  byte_results[$];
	frame_res_t  expected_results[$];
	stim_row_t   stim_rows[$];
	frame_res_t  seen_res;
	frame_res_t  want_res;
	int          errors = 0;
	bit          tx_steady = 0;
	bit          rx_steady = 0;
	int          hold_cycles = 0;

	sync_word_frame_extractor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// advance the deframer by one byte, results land in byte_results
	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] first;
		logic [7:0] cur;
		logic [3:0] len;
		int k;
		byte_results.delete();
		case (ph)
			PH_ID: begin
				ph = (b == cfg_id) ? PH_CNT : PH_WAIT;
			end
			PH_CNT: begin
				if (cnt_idx == 2'd3) begin
					byte_results.push_back('{KIND_HEADER, 8'h00, {b, cnt_bytes}, out_pos, 1'b0});
					cnt_idx = '0;
					cnt_bytes = '0;
					ph = PH_WAIT;
					collecting = 1'b1;
				end else begin
					cnt_bytes[{cnt_idx, 3'b000} +: 8] = b;
					cnt_idx = cnt_idx + 2'd1;
				end
			end
			default: begin
				first = cfg_pattern[7:0];
				cur = cfg_pattern[{match_cnt[2:0], 3'b000} +: 8];
				// broken match: replay what matched, then the breaking byte unless it is the first pattern byte
				if (collecting && b != cur) begin
					for (k = 0; k < match_cnt && k < 8; k++) begin
						byte_results.push_back('{KIND_DATA, cfg_pattern[k*8 +: 8], 32'h0,
							32'h0, 1'b0});
						out_pos = out_pos + 32'd1;
					end
					if (b != first) begin
						byte_results.push_back('{KIND_DATA, b, 32'h0, 32'h0, 1'b0});
						out_pos = out_pos + 32'd1;
					end
				end
				// first pattern byte always restarts the match
				if (b == first)
					match_cnt = 4'd1;
				else if (b == cur)
					match_cnt = match_cnt + 4'd1;
				else
					match_cnt = 4'd0;
				len = (cfg_len == 0) ? 4'd1 : (cfg_len > MAX_SOF_LEN) ? 4'(MAX_SOF_LEN) : cfg_len;
				if (match_cnt >= len) begin
					match_cnt = 4'd0;
					ph = PH_ID;
					collecting = 1'b0;
				end
			end
		endcase
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
	endtask

	// offer one byte after a random gap, predict at acceptance
	task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_any,
		input frame_res_t typed_res);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		deframe_byte(b);
		if (typed) begin
			if (typed_any)
				expected_results.push_back(typed_res);
		end else begin
			foreach (byte_results[i])
				expected_results.push_back(byte_results[i]);
		end
	endtask

	// stop offering and let the block drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SOF_PATTERN: cfg_pattern = val;
			CFG_SOF_LENGTH:  cfg_len = val[3:0];
			CFG_ID_VALUE:    cfg_id = val[7:0];
			default: ;
		endcase
	endtask

	function automatic void add_cfg(input logic [1:0] idx, input logic [63:0] val);
		stim_row_t r;
		r = '{is_cfg: 1'b1, idx: idx, val: val, b: 8'h00, typed: 1'b0, typed_any: 1'b0,
			typed_res: '0};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		stim_row_t r;
		r = '{is_cfg: 1'b0, idx: 2'd0, val: '0, b: b, typed: 1'b0, typed_any: 1'b0,
			typed_res: '0};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_typed(input logic [7:0] b, input bit any, input frame_res_t res);
		stim_row_t r;
		r = '{is_cfg: 1'b0, idx: 2'd0, val: '0, b: b, typed: 1'b1, typed_any: any,
			typed_res: res};
		stim_rows.push_back(r);
	endfunction

	// one random phase: new settings, then frames and noise
	task automatic run_phase(input int p);
		logic [63:0] pat;
		logic [3:0]  len;
		logic [7:0]  id;
		logic [7:0]  v;
		int eff;
		int sent;
		int n;
		int m;
		int k;
		int j;
		int r;
		wait_idle();
		id = 8'($urandom);
		for (k = 0; k < 8; k++)
			pat[k*8 +: 8] = ($urandom_range(0, 1) == 0) ? 8'hA5 : 8'($urandom);
		r = $urandom_range(0, 9);
		len = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
		case (p)
			0: begin
				pat = '0;
				len = 4'd15;
				id = 8'h00;
			end
			1: begin
				pat = '1;
				len = 4'd1;
				id = 8'hFF;
			end
			2: begin
				pat = {$urandom, $urandom};
				len = 4'd8;
			end
			3: len = 4'd0;
			default: ;
		endcase
		write_reg(CFG_SOF_PATTERN, pat);
		write_reg(CFG_SOF_LENGTH, {60'h0, len});
		write_reg(CFG_ID_VALUE, {56'h0, id});
		if (p == 3)
			write_reg(CFG_UNUSED, {$urandom, $urandom});
		eff = (len == 0) ? 1 : (len > MAX_SOF_LEN) ? MAX_SOF_LEN : len;
		tx_steady = (p % 4 == 2) || (p == 5);
		rx_steady = (p % 4 == 2);
		// receiver holds off while the sender keeps going
		if (p == 5)
			hold_cycles = 300;
		sent = 0;
		while (sent < 30) begin
			if ($urandom_range(0, 3) != 0) begin
				// frame with random content, its identifier byte sometimes random
				for (k = 0; k < eff; k++)
					send_byte(pat[k*8 +: 8], 1'b0, 1'b0, '0);
				v = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id;
				send_byte(v, 1'b0, 1'b0, '0);
				for (k = 0; k < 4; k++)
					send_byte(8'($urandom), 1'b0, 1'b0, '0);
				sent += eff + 5;
				n = $urandom_range(0, 10);
				for (k = 0; k < n; k++) begin
					r = $urandom_range(0, 9);
					if (r < 6 || (r < 9 && eff == 1)) begin
						send_byte(8'($urandom), 1'b0, 1'b0, '0);
						sent++;
					end else if (r < 9) begin
						// partial pattern, then a random breaking byte
						m = $urandom_range(1, eff - 1);
						for (j = 0; j < m; j++)
							send_byte(pat[j*8 +: 8], 1'b0, 1'b0, '0);
						send_byte(8'($urandom), 1'b0, 1'b0, '0);
						sent += m + 1;
					end else begin
						send_byte(pat[7:0], 1'b0, 1'b0, '0);
						sent++;
					end
				end
			end else begin
				// noise burst
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					send_byte(8'($urandom), 1'b0, 1'b0, '0);
				sent += n;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input frame_res_t want,
		input frame_res_t got);
		errors++;
		if (errors <= 10)
			$display({"%s: exp kind %0d byte %02h cnt %08h pos %08h last %0d,",
				" got kind %0d byte %02h cnt %08h pos %08h last %0d"},
				what, want.kind, want.data, want.count, want.pos, want.last,
				got.kind, got.data, got.count, got.pos, got.last);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_res = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
				m_axis_tdata[71:40], m_axis_tlast};
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected item", '0, seen_res);
			end else begin
				want_res = expected_results.pop_front();
				if (seen_res !== want_res)
					report_mismatch("mismatch", want_res, seen_res);
			end
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin : receiver
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// main sequence
	initial begin : main
		stim_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;

		// reset settings: zero pattern of one byte, zero identifier
		add_typed(8'h00, 1'b0, '0);
		add_typed(8'h00, 1'b0, '0);
		add_typed(8'hFF, 1'b0, '0);
		add_typed(8'hFF, 1'b0, '0);
		add_typed(8'hFF, 1'b0, '0);
		add_typed(8'hFF, 1'b1, '{KIND_HEADER, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b1});
		add_typed(8'h55, 1'b1, '{KIND_DATA, 8'h55, 32'h0, 32'h0, 1'b1});
		add_typed(8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 32'h0, 32'h0, 1'b1});
		// three-byte pattern: broken match replay, restart on first byte
		add_cfg(CFG_SOF_PATTERN, 64'h0000_0000_00C3_B2A1);
		add_cfg(CFG_SOF_LENGTH, 64'd3);
		add_byte(8'hA1);
		add_byte(8'hB2);
		add_byte(8'h12);
		add_byte(8'hA1);
		add_byte(8'hB2);
		add_byte(8'hA1);
		// length lowered to zero mid-match, then identifier mismatch
		add_cfg(CFG_SOF_LENGTH, 64'd0);
		add_cfg(CFG_ID_VALUE, 64'h5A);
		add_typed(8'hB2, 1'b0, '0);
		add_typed(8'h00, 1'b0, '0);
		add_typed(8'h80, 1'b0, '0);
		add_typed(8'h7F, 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		while (stim_rows.size() > 0) begin
			row = stim_rows.pop_front();
			if (row.is_cfg) begin
				wait_idle();
				write_reg(row.idx, row.val);
			end else begin
				send_byte(row.b, row.typed, row.typed_any, row.typed_res);
			end
		end

		for (int p = 0; p < 9; p++)
			run_phase(p);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sfx_pkg.sv
src/sfx_ctrl.sv
src/sfx_dp.sv
src/sync_word_frame_extractor_unit.sv
tb/tb_top.sv
